// File: rtl/lse_pkg.sv
// Shared types, constants and helper functions for the LSB payload extractor.
package lse_pkg;

	localparam int CAPACITY_BITS = 24;
	localparam int DIV_BITS      = 36;
	localparam logic [31:0] MARKER_WORD = 32'h5441_4442;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// decoder phase: which field of the hidden stream comes next
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_MARKER  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_SKIP    = 3'd3,
		PH_PAYLEN  = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CRC     = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_LENGTH  = 3'd1,
		STS_WIDTH   = 3'd2,
		STS_MARKER  = 3'd3,
		STS_CRC     = 3'd4
	} status_t;

	// what the decode of one item leads to
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_STATUS = 3'd1,
		EV_DIV    = 3'd2,
		EV_CHECK  = 3'd3,
		EV_CHUNK  = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_BYTE  = 3'd1,
		ST_DIV   = 3'd2,
		ST_ADD   = 3'd3,
		ST_CHECK = 3'd4,
		ST_CHUNK = 3'd5,
		ST_STAT  = 3'd6
	} state_t;

	localparam logic CFG_CHUNK_BITS = 1'b0;
	localparam logic CFG_CAPACITY   = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic div_step;
		logic add;
		logic advance;
		logic fail;
		logic emit_status;
		logic emit_chunk;
	} cmd_t;

	typedef struct packed {
		event_t ev;
		logic   div_last;
		logic   fits;
		logic   out_free;
		logic   chunk_last;
	} stat_t;

	// color bytes needed for a 4-byte field at b hidden bits per byte
	function automatic logic [5:0] len4(input logic [2:0] b);
		logic [5:0] r;
		case (b)
			3'd1:    r = 6'd32;
			3'd2:    r = 6'd16;
			3'd3:    r = 6'd11;
			default: r = 6'd8;
		endcase
		return r;
	endfunction

	// color bytes needed for a 2-byte field
	function automatic logic [5:0] len2(input logic [2:0] b);
		logic [5:0] r;
		case (b)
			3'd1:    r = 6'd16;
			3'd2:    r = 6'd8;
			3'd3:    r = 6'd6;
			default: r = 6'd4;
		endcase
		return r;
	endfunction

	// one CRC-CCITT byte update, MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {d, 8'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/lse_ctrl.sv
// Sequencing state machine of the payload extractor.
module lse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  lse_pkg::stat_t  stat,
	output lse_pkg::cmd_t   cmd
);

	lse_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lse_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lse_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = lse_pkg::ST_BYTE;
			end
			lse_pkg::ST_BYTE: begin
				case (stat.ev)
					lse_pkg::EV_STATUS: state_d = lse_pkg::ST_STAT;
					lse_pkg::EV_DIV:    state_d = lse_pkg::ST_DIV;
					lse_pkg::EV_CHECK:  state_d = lse_pkg::ST_CHECK;
					lse_pkg::EV_CHUNK:  state_d = lse_pkg::ST_CHUNK;
					default:            state_d = lse_pkg::ST_IDLE;
				endcase
			end
			lse_pkg::ST_DIV: begin
				if (stat.div_last) state_d = lse_pkg::ST_ADD;
			end
			lse_pkg::ST_ADD:   state_d = lse_pkg::ST_CHECK;
			lse_pkg::ST_CHECK: state_d = stat.fits ? lse_pkg::ST_IDLE : lse_pkg::ST_STAT;
			lse_pkg::ST_CHUNK: begin
				if (stat.out_free && stat.chunk_last) state_d = lse_pkg::ST_IDLE;
			end
			lse_pkg::ST_STAT: begin
				if (stat.out_free) state_d = lse_pkg::ST_IDLE;
			end
			default: state_d = lse_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			lse_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			lse_pkg::ST_BYTE:  cmd.step        = 1'b1;
			lse_pkg::ST_DIV:   cmd.div_step    = 1'b1;
			lse_pkg::ST_ADD:   cmd.add         = 1'b1;
			lse_pkg::ST_CHECK: begin
				cmd.advance = stat.fits;
				cmd.fail    = !stat.fits;
			end
			lse_pkg::ST_CHUNK: cmd.emit_chunk  = stat.out_free;
			lse_pkg::ST_STAT:  cmd.emit_status = stat.out_free;
			default: ;
		endcase
	end

endmodule

// File: rtl/lse_dp.sv
// Datapath: bit unpacking, field decode, CRC, length divider and output register.
module lse_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  lse_pkg::cmd_t   cmd,
	output lse_pkg::stat_t  stat,
	input  logic [7:0]      s_tdata,
	input  logic            s_tuser,
	input  logic            cfg_valid,
	input  logic            cfg_index,
	input  logic [23:0]     cfg_data,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);

	// configuration
	logic [3:0]  chunk_bits_q;
	logic [lse_pkg::CAPACITY_BITS-1:0] cap_q;

	// request in flight
	logic [7:0]  item_byte_q;
	logic        item_first_q;

	// decoder state
	lse_pkg::phase_t  phase_q;
	lse_pkg::status_t code_q;
	logic [2:0]  bpb_q;
	logic [11:0] acc_q;
	logic [3:0]  cnt_q;
	logic [31:0] left_q;
	logic [31:0] field_q;
	logic [15:0] ext_q;
	logic [31:0] pay_q;
	logic [39:0] req_q;
	logic [15:0] crc_q;

	// divider
	logic [lse_pkg::DIV_BITS-1:0] quo_q;
	logic [2:0]  rem_q;
	logic [5:0]  div_cnt_q;

	// chunk emission
	logic [7:0]  pbyte_q;
	logic [3:0]  pbits_q;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_chunk_q;
	lse_pkg::status_t out_status_q;
	logic        out_last_q;

	logic [3:0]  b_first;
	logic        active;
	logic [7:0]  bmask;
	logic [11:0] acc_n;
	logic [3:0]  cnt_sum, cnt_n;
	logic        byte_rdy;
	logic [7:0]  byte_v;
	logic [2:0]  fld_total;
	logic [1:0]  pos;
	logic [31:0] fld_new;
	logic        fld_last;
	logic [31:0] len_n;
	lse_pkg::event_t  ev;
	lse_pkg::status_t ev_code;
	logic [3:0]  rdiv;
	logic        ge;
	logic [3:0]  w_eff;
	logic [7:0]  wmask;
	logic [5:0]  len_const;

	// width code of a first byte: one plus the trailing ones
	always_comb begin
		casez (item_byte_q[3:0])
			4'b???0: b_first = 4'd1;
			4'b??01: b_first = 4'd2;
			4'b?011: b_first = 4'd3;
			4'b0111: b_first = 4'd4;
			default: b_first = 4'd5;
		endcase
	end

	// bit unpacking
	always_comb begin
		active   = (phase_q != lse_pkg::PH_IDLE) && (phase_q != lse_pkg::PH_DONE) &&
		           (bpb_q != 3'd0) && (bpb_q <= 3'd4);
		bmask    = 8'((9'd1 << bpb_q) - 9'd1);
		acc_n    = 12'((acc_q << bpb_q) | {4'd0, item_byte_q & bmask});
		cnt_sum  = 4'(cnt_q + {1'b0, bpb_q});
		byte_rdy = cnt_sum >= 4'd8;
		cnt_n    = byte_rdy ? 4'(cnt_sum - 4'd8) : cnt_sum;
		byte_v   = 8'(acc_n >> cnt_n);
		fld_total = ((phase_q == lse_pkg::PH_MARKER) || (phase_q == lse_pkg::PH_PAYLEN)) ?
		            3'd4 : 3'd2;
		pos      = 2'(fld_total - left_q[2:0]);
		fld_new  = field_q | (32'(byte_v) << {pos, 3'b000});
		fld_last = left_q == 32'd1;
		len_n    = (phase_q == lse_pkg::PH_EXTLEN) ? {16'd0, fld_new[15:0]} : fld_new;
	end

	// outcome of decoding the current request
	always_comb begin
		ev      = lse_pkg::EV_NONE;
		ev_code = lse_pkg::STS_OK;
		if (item_first_q) begin
			if (b_first > 4'd4) begin
				ev      = lse_pkg::EV_STATUS;
				ev_code = lse_pkg::STS_WIDTH;
			end else begin
				ev = lse_pkg::EV_CHECK;
			end
		end else if (active && byte_rdy) begin
			case (phase_q)
				lse_pkg::PH_MARKER: begin
					if (fld_last && fld_new != lse_pkg::MARKER_WORD) begin
						ev      = lse_pkg::EV_STATUS;
						ev_code = lse_pkg::STS_MARKER;
					end
				end
				lse_pkg::PH_EXTLEN, lse_pkg::PH_PAYLEN: begin
					if (fld_last) ev = lse_pkg::EV_DIV;
				end
				lse_pkg::PH_CRC: begin
					if (fld_last) begin
						ev      = lse_pkg::EV_STATUS;
						ev_code = (fld_new[15:0] == crc_q) ? lse_pkg::STS_OK : lse_pkg::STS_CRC;
					end
				end
				lse_pkg::PH_PAYLOAD: ev = lse_pkg::EV_CHUNK;
				default: ;
			endcase
		end
	end

	// divider step, chunk width and constant length term
	always_comb begin
		rdiv      = {rem_q, quo_q[lse_pkg::DIV_BITS-1]};
		ge        = rdiv >= {1'b0, bpb_q};
		w_eff     = ((chunk_bits_q == 4'd1) || (chunk_bits_q == 4'd2) ||
		             (chunk_bits_q == 4'd4)) ? chunk_bits_q : 4'd8;
		wmask     = 8'((9'd1 << w_eff) - 9'd1);
		len_const = (phase_q == lse_pkg::PH_EXTLEN) ? lse_pkg::len4(bpb_q) :
		            lse_pkg::len2(bpb_q);
	end

	always_comb begin
		stat.ev         = ev;
		stat.div_last   = div_cnt_q == 6'(lse_pkg::DIV_BITS - 1);
		stat.fits       = req_q <= 40'(cap_q);
		stat.out_free   = !out_valid_q || m_tready;
		stat.chunk_last = pbits_q <= w_eff;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bits_q <= 4'd8;
			cap_q        <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == lse_pkg::CFG_CHUNK_BITS) chunk_bits_q <= cfg_data[3:0];
			else cap_q <= cfg_data[lse_pkg::CAPACITY_BITS-1:0];
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_byte_q  <= s_tdata;
			item_first_q <= s_tuser;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lse_pkg::PH_IDLE;
			code_q    <= lse_pkg::STS_OK;
			bpb_q     <= '0;
			acc_q     <= '0;
			cnt_q     <= '0;
			left_q    <= '0;
			field_q   <= '0;
			ext_q     <= '0;
			pay_q     <= '0;
			req_q     <= '0;
			crc_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			pbyte_q   <= '0;
			pbits_q   <= '0;
		end else begin
			if (cmd.step) begin
				if (ev == lse_pkg::EV_STATUS) code_q <= ev_code;
				if (item_first_q) begin
					// restart on a new image
					phase_q <= lse_pkg::PH_IDLE;
					ext_q   <= '0;
					pay_q   <= '0;
					crc_q   <= '0;
					left_q  <= '0;
					field_q <= '0;
					acc_q   <= '0;
					cnt_q   <= '0;
					if (b_first > 4'd4) begin
						bpb_q <= '0;
						req_q <= '0;
					end else begin
						bpb_q <= b_first[2:0];
						req_q <= 40'd1 + 40'(lse_pkg::len4(b_first[2:0])) +
						         40'(lse_pkg::len2(b_first[2:0]));
					end
				end else if (active) begin
					acc_q <= acc_n;
					cnt_q <= cnt_n;
					if (byte_rdy) begin
						if (phase_q != lse_pkg::PH_CRC) crc_q <= lse_pkg::crc_step(crc_q, byte_v);
						left_q <= left_q - 32'd1;
						case (phase_q)
							lse_pkg::PH_MARKER, lse_pkg::PH_EXTLEN,
							lse_pkg::PH_PAYLEN, lse_pkg::PH_CRC: begin
								field_q <= fld_new;
								if (fld_last) begin
									if (phase_q == lse_pkg::PH_MARKER) begin
										phase_q <= lse_pkg::PH_EXTLEN;
										left_q  <= 32'd2;
										field_q <= '0;
										acc_q   <= '0;
										cnt_q   <= '0;
									end
									if (phase_q == lse_pkg::PH_EXTLEN) ext_q <= fld_new[15:0];
									if (phase_q == lse_pkg::PH_PAYLEN) pay_q <= fld_new;
									// dividend: 8n + b - 1
									quo_q     <= 36'({len_n, 3'b000}) + 36'(bpb_q - 3'd1);
									rem_q     <= '0;
									div_cnt_q <= '0;
								end
							end
							lse_pkg::PH_SKIP: begin
								if (fld_last) begin
									phase_q <= lse_pkg::PH_PAYLEN;
									left_q  <= 32'd4;
									field_q <= '0;
									acc_q   <= '0;
									cnt_q   <= '0;
								end
							end
							lse_pkg::PH_PAYLOAD: begin
								pbyte_q <= byte_v;
								pbits_q <= 4'd8;
								if (fld_last) begin
									phase_q <= lse_pkg::PH_CRC;
									left_q  <= 32'd2;
									field_q <= '0;
									acc_q   <= '0;
									cnt_q   <= '0;
								end
							end
							default: ;
						endcase
					end
				end
			end

			// restoring divide by bits per byte, one quotient bit a cycle
			if (cmd.div_step) begin
				rem_q     <= ge ? 3'(rdiv - {1'b0, bpb_q}) : rdiv[2:0];
				quo_q     <= {quo_q[lse_pkg::DIV_BITS-2:0], ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end

			if (cmd.add) req_q <= req_q + 40'(quo_q) + 40'(len_const);

			if (cmd.fail) code_q <= lse_pkg::STS_LENGTH;

			// open the next field once the length check passed
			if (cmd.advance) begin
				field_q <= '0;
				acc_q   <= '0;
				cnt_q   <= '0;
				case (phase_q)
					lse_pkg::PH_IDLE: begin
						phase_q <= lse_pkg::PH_MARKER;
						left_q  <= 32'd4;
					end
					lse_pkg::PH_EXTLEN: begin
						if (ext_q != 16'd0) begin
							phase_q <= lse_pkg::PH_SKIP;
							left_q  <= 32'(ext_q);
						end else begin
							phase_q <= lse_pkg::PH_PAYLEN;
							left_q  <= 32'd4;
						end
					end
					lse_pkg::PH_PAYLEN: begin
						if (pay_q != 32'd0) begin
							phase_q <= lse_pkg::PH_PAYLOAD;
							left_q  <= pay_q;
						end else begin
							phase_q <= lse_pkg::PH_CRC;
							left_q  <= 32'd2;
						end
					end
					default: ;
				endcase
			end

			if (cmd.emit_status) phase_q <= lse_pkg::PH_DONE;

			if (cmd.emit_chunk) begin
				pbyte_q <= 8'(pbyte_q >> w_eff);
				pbits_q <= 4'(pbits_q - w_eff);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_chunk || cmd.emit_status) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_chunk) begin
			out_kind_q   <= 1'b0;
			out_chunk_q  <= pbyte_q & wmask;
			out_status_q <= lse_pkg::STS_OK;
			out_last_q   <= pbits_q <= w_eff;
		end else if (cmd.emit_status) begin
			out_kind_q   <= 1'b1;
			out_chunk_q  <= '0;
			out_status_q <= code_q;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_status_q, out_chunk_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/lsb_stego_payload_extractor.sv
// Top level of the LSB steganography payload extractor.
// Takes bitmap color bytes one per request, recovers the hidden stream
// (marker, extra length, skipped bytes, payload length, payload, CRC-16)
// and returns each payload byte as 1, 2, 4 or 8-bit chunks, lowest first,
// followed by one status per run. A color byte is latched and then decoded;
// a first byte with a valid width code then also gets its capacity check.
// A byte that completes a payload byte then emits its chunks one at a time,
// each gated by the output register; a byte that ends a run with a status
// then emits it, also gated by the output register; a byte that completes a
// length field then runs the bit-serial divide by the hidden bits per byte,
// an add and the capacity check, and emits a status when that check fails.
// The input is held off until the request in flight is done. Configuration
// writes are always taken (cfg_ready is tied high).
module lsb_stego_payload_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] color_byte
	input  logic        s_tuser,   // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] chunk_value, [10:8] status
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	lse_pkg::cmd_t  cmd;
	lse_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	lse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
